>>> hdl/fca_pkg.sv
package fca_pkg;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_SHL = 3'd4;
  localparam logic [2:0] OP_SHR = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DIV_ZERO  = 2'd1;
  localparam logic [1:0] ST_NEG_SHIFT = 2'd2;

  localparam logic [31:0] QNAN = 32'h7FC0_0000;

  localparam int DIV_STAGES = 14;
  localparam int QW         = 2 * DIV_STAGES;

  typedef logic signed [11:0] exp_t;

  // Operands after unpacking: normalized mantissas with hidden bit, signed biased exponents.
  typedef struct packed {
    logic [2:0]  op;
    logic        special;
    logic [31:0] spec_val;
    logic [1:0]  status;
    logic        sa;
    logic        sb;
    exp_t        ea;
    exp_t        eb;
    logic [23:0] ma;
    logic [23:0] mb;
    logic [31:0] ival;
  } op_rec_t;

  // Unrounded number: value = m / 2^31 * 2^(e - 127).
  typedef struct packed {
    logic        special;
    logic [31:0] spec_val;
    logic [1:0]  status;
    logic        sign;
    exp_t        e;
    logic [31:0] m;
  } num_t;

  function automatic logic [5:0] lzc32(input logic [31:0] x);
    logic [5:0] n;
    logic       found;
    n     = 6'd32;
    found = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (!found && x[i]) begin
        n     = 6'(31 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

>>> hdl/fca_unpack.sv
module fca_unpack (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [2:0]       op,
  input  logic [31:0]      xa,
  input  logic [31:0]      xb,
  output logic             out_valid,
  output fca_pkg::op_rec_t rec
);
  import fca_pkg::*;

  typedef struct packed {
    logic [2:0]  op;
    logic        special;
    logic [31:0] spec_val;
    logic [1:0]  status;
    logic        sa;
    logic        sb;
    logic [7:0]  ea;
    logic [22:0] fa;
    logic [7:0]  eb;
    logic [22:0] fb;
    logic [31:0] ival;
    logic        cnt_big;
    logic [4:0]  amt;
  } s1_t;

  function automatic logic [31:0] to_int(input logic [31:0] b);
    logic [7:0]  ex;
    logic [55:0] sh;
    logic [31:0] mag;
    logic [31:0] res;
    ex  = b[30:23];
    sh  = {32'd0, 1'b1, b[22:0]} << (ex - 8'd127);
    mag = sh[54:23];
    if (ex == 8'hFF && b[22:0] != 23'd0) begin
      res = 32'd0;
    end else if (ex < 8'd127) begin
      res = 32'd0;
    end else if (ex >= 8'd158) begin
      res = b[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      res = b[31] ? (~mag + 32'd1) : mag;
    end
    return res;
  endfunction

  s1_t         s1_nxt, s1_r;
  logic        v1_r;
  op_rec_t     rec_nxt, rec_r;
  logic        v2_r;

  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sx, sbe;
  logic [31:0] cnt;

  always_comb begin
    a_nan  = (xa[30:23] == 8'hFF) && (xa[22:0] != 23'd0);
    b_nan  = (xb[30:23] == 8'hFF) && (xb[22:0] != 23'd0);
    a_inf  = (xa[30:23] == 8'hFF) && (xa[22:0] == 23'd0);
    b_inf  = (xb[30:23] == 8'hFF) && (xb[22:0] == 23'd0);
    a_zero = (xa[30:0] == 31'd0);
    b_zero = (xb[30:0] == 31'd0);
    sbe    = xb[31] ^ (op == OP_SUB);
    sx     = xa[31] ^ xb[31];
    cnt    = to_int(xb);

    s1_nxt          = '0;
    s1_nxt.op       = op;
    s1_nxt.sa       = xa[31];
    s1_nxt.sb       = sbe;
    s1_nxt.ea       = xa[30:23];
    s1_nxt.fa       = xa[22:0];
    s1_nxt.eb       = xb[30:23];
    s1_nxt.fb       = xb[22:0];
    s1_nxt.ival     = to_int(xa);
    s1_nxt.cnt_big  = |cnt[30:5];
    s1_nxt.amt      = cnt[4:0];
    s1_nxt.status   = ST_OK;
    s1_nxt.special  = 1'b0;
    s1_nxt.spec_val = 32'd0;

    unique case (op) inside
      OP_ADD, OP_SUB: begin
        s1_nxt.special = 1'b1;
        if (a_nan || b_nan || (a_inf && b_inf && (xa[31] != sbe))) begin
          s1_nxt.spec_val = QNAN;
        end else if (a_inf) begin
          s1_nxt.spec_val = {xa[31], 8'hFF, 23'd0};
        end else if (b_inf) begin
          s1_nxt.spec_val = {sbe, 8'hFF, 23'd0};
        end else if (a_zero && b_zero) begin
          s1_nxt.spec_val = {xa[31] & sbe, 31'd0};
        end else if (a_zero) begin
          s1_nxt.spec_val = {sbe, xb[30:0]};
        end else if (b_zero) begin
          s1_nxt.spec_val = xa;
        end else begin
          s1_nxt.special = 1'b0;
        end
      end
      OP_MUL: begin
        s1_nxt.special = 1'b1;
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
          s1_nxt.spec_val = QNAN;
        end else if (a_inf || b_inf) begin
          s1_nxt.spec_val = {sx, 8'hFF, 23'd0};
        end else if (a_zero || b_zero) begin
          s1_nxt.spec_val = {sx, 31'd0};
        end else begin
          s1_nxt.special = 1'b0;
        end
      end
      OP_DIV: begin
        s1_nxt.special = 1'b1;
        if (b_zero) begin
          s1_nxt.status = ST_DIV_ZERO;
        end else if (a_nan || b_nan || (a_inf && b_inf)) begin
          s1_nxt.spec_val = QNAN;
        end else if (a_inf) begin
          s1_nxt.spec_val = {sx, 8'hFF, 23'd0};
        end else if (b_inf || a_zero) begin
          s1_nxt.spec_val = {sx, 31'd0};
        end else begin
          s1_nxt.special = 1'b0;
        end
      end
      OP_SHL, OP_SHR: begin
        if (cnt[31]) begin
          s1_nxt.special = 1'b1;
          s1_nxt.status  = ST_NEG_SHIFT;
        end
      end
      default: begin
        s1_nxt.special = 1'b1;
      end
    endcase
  end

  logic [23:0] ma_raw, mb_raw;
  logic [5:0]  lza, lzb;
  logic [7:0]  ea_eff, eb_eff;
  logic [31:0] shl_v, shr_v;

  always_comb begin
    ma_raw = {s1_r.ea != 8'd0, s1_r.fa};
    mb_raw = {s1_r.eb != 8'd0, s1_r.fb};
    lza    = lzc32({ma_raw, 8'hFF});
    lzb    = lzc32({mb_raw, 8'hFF});
    ea_eff = (s1_r.ea == 8'd0) ? 8'd1 : s1_r.ea;
    eb_eff = (s1_r.eb == 8'd0) ? 8'd1 : s1_r.eb;

    if (s1_r.cnt_big) begin
      shl_v = 32'd0;
      shr_v = {32{s1_r.ival[31]}};
    end else begin
      shl_v = s1_r.ival << s1_r.amt;
      shr_v = $signed(s1_r.ival) >>> s1_r.amt;
    end

    rec_nxt          = '0;
    rec_nxt.op       = s1_r.op;
    rec_nxt.special  = s1_r.special;
    rec_nxt.spec_val = s1_r.spec_val;
    rec_nxt.status   = s1_r.status;
    rec_nxt.sa       = s1_r.sa;
    rec_nxt.sb       = s1_r.sb;
    rec_nxt.ma       = ma_raw << lza[4:0];
    rec_nxt.mb       = mb_raw << lzb[4:0];
    rec_nxt.ea       = $signed({4'd0, ea_eff}) - $signed({7'd0, lza[4:0]});
    rec_nxt.eb       = $signed({4'd0, eb_eff}) - $signed({7'd0, lzb[4:0]});
    rec_nxt.ival     = (s1_r.op == OP_SHL) ? shl_v : shr_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r  <= s1_nxt;
      rec_r <= rec_nxt;
    end
  end

  assign out_valid = v2_r;
  assign rec       = rec_r;

endmodule

>>> hdl/fca_divider.sv
module fca_divider (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  fca_pkg::op_rec_t         in_rec,
  output logic                     out_valid,
  output fca_pkg::op_rec_t         out_rec,
  output logic [fca_pkg::QW-1:0]   quo,
  output logic                     rem_nz
);
  import fca_pkg::*;

  logic        v_r   [DIV_STAGES];
  op_rec_t     rec_r [DIV_STAGES];
  logic [24:0] rem_r [DIV_STAGES];
  logic [QW-1:0] quo_r [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic          v_in;
    op_rec_t       rec_in;
    logic [24:0]   rem_in, dv, r1, r1s, r2;
    logic [QW-1:0] quo_in;
    logic          b1, b0;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign rec_in = in_rec;
      assign rem_in = {1'b0, in_rec.ma};
      assign quo_in = '0;
    end else begin : g_next
      assign v_in   = v_r[k-1];
      assign rec_in = rec_r[k-1];
      assign rem_in = rem_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    always_comb begin
      dv  = {1'b0, rec_in.mb};
      b1  = (rem_in >= dv);
      r1  = b1 ? (rem_in - dv) : rem_in;
      r1s = {r1[23:0], 1'b0};
      b0  = (r1s >= dv);
      r2  = b0 ? (r1s - dv) : r1s;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rec_r[k] <= rec_in;
        rem_r[k] <= {r2[23:0], 1'b0};
        quo_r[k] <= {quo_in[QW-3:0], b1, b0};
      end
    end
  end

  assign out_valid = v_r[DIV_STAGES-1];
  assign out_rec   = rec_r[DIV_STAGES-1];
  assign quo       = quo_r[DIV_STAGES-1];
  assign rem_nz    = (rem_r[DIV_STAGES-1] != 25'd0);

endmodule

>>> hdl/fca_arith.sv
module fca_arith (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  fca_pkg::op_rec_t       rec,
  input  logic [fca_pkg::QW-1:0] quo,
  input  logic                   rem_nz,
  output logic                   out_valid,
  output fca_pkg::num_t          num
);
  import fca_pkg::*;

  typedef struct packed {
    logic [2:0]  op;
    logic        special;
    logic [31:0] spec_val;
    logic [1:0]  status;
    logic        sign;
    exp_t        e;
    logic [31:0] m_dir;
    logic [31:0] big;
    logic [31:0] sml;
    logic        sub;
    logic [47:0] prod;
  } a1_t;

  a1_t         a1_nxt, a1_r;
  logic        v1_r, v2_r;
  num_t        num_nxt, num_r;

  logic        a_big;
  exp_t        e_big, e_sml, diff;
  logic [23:0] m_big, m_sml;
  logic [31:0] sml_full, sml_al, mag;

  always_comb begin
    a_big    = (rec.ea > rec.eb) || ((rec.ea == rec.eb) && (rec.ma >= rec.mb));
    e_big    = a_big ? rec.ea : rec.eb;
    e_sml    = a_big ? rec.eb : rec.ea;
    m_big    = a_big ? rec.ma : rec.mb;
    m_sml    = a_big ? rec.mb : rec.ma;
    diff     = e_big - e_sml;
    sml_full = {1'b0, m_sml, 7'd0};
    if (diff > 12'sd30) begin
      sml_al = 32'd1;
    end else begin
      sml_al    = sml_full >> diff[4:0];
      sml_al[0] = sml_al[0] | (|(sml_full & ((32'd1 << diff[4:0]) - 32'd1)));
    end
    mag = rec.ival[31] ? (~rec.ival + 32'd1) : rec.ival;

    a1_nxt          = '0;
    a1_nxt.op       = rec.op;
    a1_nxt.special  = rec.special;
    a1_nxt.spec_val = rec.spec_val;
    a1_nxt.status   = rec.status;
    a1_nxt.big      = {1'b0, m_big, 7'd0};
    a1_nxt.sml      = sml_al;
    a1_nxt.sub      = rec.sa ^ rec.sb;
    a1_nxt.prod     = rec.ma * rec.mb;

    case (rec.op) inside
      OP_ADD, OP_SUB: begin
        a1_nxt.sign  = a_big ? rec.sa : rec.sb;
        a1_nxt.e     = e_big + 12'sd1;
        a1_nxt.m_dir = 32'd0;
      end
      OP_MUL: begin
        a1_nxt.sign  = rec.sa ^ rec.sb;
        a1_nxt.e     = rec.ea + rec.eb - 12'sd126;
        a1_nxt.m_dir = 32'd0;
      end
      OP_DIV: begin
        a1_nxt.sign  = rec.sa ^ rec.sb;
        a1_nxt.e     = rec.ea - rec.eb + 12'sd127;
        a1_nxt.m_dir = {quo, rem_nz, 3'd0};
      end
      default: begin
        a1_nxt.sign  = rec.ival[31];
        a1_nxt.e     = 12'sd158;
        a1_nxt.m_dir = mag;
      end
    endcase
  end

  always_comb begin
    num_nxt.special  = a1_r.special;
    num_nxt.spec_val = a1_r.spec_val;
    num_nxt.status   = a1_r.status;
    num_nxt.sign     = a1_r.sign;
    num_nxt.e        = a1_r.e;
    case (a1_r.op) inside
      OP_ADD, OP_SUB: num_nxt.m = a1_r.sub ? (a1_r.big - a1_r.sml) : (a1_r.big + a1_r.sml);
      OP_MUL:         num_nxt.m = {a1_r.prod[47:17], |a1_r.prod[16:0]};
      default:        num_nxt.m = a1_r.m_dir;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r  <= a1_nxt;
      num_r <= num_nxt;
    end
  end

  assign out_valid = v2_r;
  assign num       = num_r;

endmodule

>>> hdl/fca_norm_round.sv
module fca_norm_round (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  fca_pkg::num_t num,
  output logic          out_valid,
  output logic [31:0]   result,
  output logic [1:0]    status
);
  import fca_pkg::*;

  typedef struct packed {
    logic        special;
    logic [31:0] spec_val;
    logic [1:0]  status;
    logic        sign;
    logic        zero;
    exp_t        e;
    logic [31:0] m;
  } nr_t;

  typedef struct packed {
    nr_t        base;
    logic [4:0] lsh;
    logic [5:0] rsh;
  } n1_t;

  n1_t         n1_nxt, n1_r;
  nr_t         n2_nxt, n2_r;
  logic        v1_r, v2_r, v3_r;
  logic [31:0] res_nxt, res_r;
  logic [1:0]  st_r;

  logic [5:0]  lz;
  exp_t        lz_s, em1, rr;

  always_comb begin
    lz   = lzc32(num.m);
    lz_s = $signed({6'd0, lz});
    em1  = num.e - 12'sd1;
    rr   = 12'sd1 - num.e;

    n1_nxt.base.special  = num.special;
    n1_nxt.base.spec_val = num.spec_val;
    n1_nxt.base.status   = num.status;
    n1_nxt.base.sign     = num.sign;
    n1_nxt.base.zero     = (num.m == 32'd0);
    n1_nxt.base.m        = num.m;
    n1_nxt.lsh           = 5'd0;
    n1_nxt.rsh           = 6'd0;
    if (num.e > lz_s) begin
      n1_nxt.lsh    = lz[4:0];
      n1_nxt.base.e = num.e - lz_s;
    end else if (num.e >= 12'sd1) begin
      n1_nxt.lsh    = em1[4:0];
      n1_nxt.base.e = 12'sd1;
    end else begin
      n1_nxt.rsh    = (num.e < -12'sd30) ? 6'd32 : rr[5:0];
      n1_nxt.base.e = 12'sd1;
    end
  end

  always_comb begin
    n2_nxt = n1_r.base;
    if (n1_r.rsh[5]) begin
      n2_nxt.m = {31'd0, |n1_r.base.m};
    end else if (n1_r.rsh != 6'd0) begin
      n2_nxt.m    = n1_r.base.m >> n1_r.rsh[4:0];
      n2_nxt.m[0] = n2_nxt.m[0]
                    | (|(n1_r.base.m & ((32'd1 << n1_r.rsh[4:0]) - 32'd1)));
    end else begin
      n2_nxt.m = n1_r.base.m << n1_r.lsh;
    end
  end

  logic [23:0] mant, mf;
  logic [24:0] m25;
  logic        up;
  exp_t        ef;

  always_comb begin
    mant = n2_r.m[31:8];
    up   = n2_r.m[7] & ((|n2_r.m[6:0]) | mant[0]);
    m25  = {1'b0, mant} + {24'd0, up};
    if (m25[24]) begin
      mf = 24'h80_0000;
      ef = n2_r.e + 12'sd1;
    end else begin
      mf = m25[23:0];
      ef = n2_r.e;
    end
    if (n2_r.special) begin
      res_nxt = n2_r.spec_val;
    end else if (n2_r.zero) begin
      res_nxt = 32'd0;
    end else if (ef >= 12'sd255) begin
      res_nxt = {n2_r.sign, 8'hFF, 23'd0};
    end else begin
      res_nxt = {n2_r.sign, (mf[23] ? ef[7:0] : 8'd0), mf[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_r  <= n1_nxt;
      n2_r  <= n2_nxt;
      res_r <= res_nxt;
      st_r  <= n2_r.status;
    end
  end

  assign out_valid = v3_r;
  assign result    = res_r;
  assign status    = st_r;

endmodule

>>> hdl/float_calculator_alu.sv
// Channel  Direction  tdata                                   tuser
// in_      slave      [31:0] first_operand, [63:32] second_op.  [2:0] operation
// out_     master     [31:0] result_value                      [1:0] status
//
// One word enters per cycle while the pipeline is not held; see the hold rule below.
// The pipeline is built around the 14-stage divider array, two quotient bits per stage,
// with two unpack stages ahead of it and five arithmetic and rounding stages after.
// Reset clears the valid bits of every stage; data registers are not reset.
// When out_tready is low with a result waiting, the whole pipeline holds in place.
module float_calculator_alu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // first_operand, second_operand
  input  logic [2:0]  in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // result_value
  output logic [1:0]  out_tuser   // status
);
  import fca_pkg::*;

  logic          en;
  logic          up_valid, dv_valid, ar_valid;
  op_rec_t       up_rec, dv_rec;
  logic [QW-1:0] dv_quo;
  logic          dv_rem_nz;
  num_t          ar_num;

  assign en        = out_tready | ~out_tvalid;
  assign in_tready = en;

  fca_unpack u_unpack (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .op        (in_tuser),
    .xa        (in_tdata[31:0]),
    .xb        (in_tdata[63:32]),
    .out_valid (up_valid),
    .rec       (up_rec)
  );

  fca_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (up_valid),
    .in_rec    (up_rec),
    .out_valid (dv_valid),
    .out_rec   (dv_rec),
    .quo       (dv_quo),
    .rem_nz    (dv_rem_nz)
  );

  fca_arith u_arith (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dv_valid),
    .rec       (dv_rec),
    .quo       (dv_quo),
    .rem_nz    (dv_rem_nz),
    .out_valid (ar_valid),
    .num       (ar_num)
  );

  fca_norm_round u_norm_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (ar_valid),
    .num       (ar_num),
    .out_valid (out_tvalid),
    .result    (out_tdata),
    .status    (out_tuser)
  );

  a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> out_tdata == 32'd0)
    else $error("error status with nonzero result");

  a_status_code : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_DIV_ZERO ||
                    out_tuser == ST_NEG_SHIFT))
    else $error("undefined status code");

  a_nan_canon : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[30:23] == 8'hFF) && (out_tdata[22:0] != 23'd0)
      |-> out_tdata == QNAN)
    else $error("non-canonical NaN result");

endmodule
